@@ src/afs_pkg.sv @@
package afs_pkg;

  localparam int unsigned HEADER_BYTES     = 10;
  localparam int unsigned FRAMES_PER_POINT = 43;

  localparam int unsigned HDR_KEEP   = 6;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_KEEP);
  localparam int unsigned BIDX_W     = $clog2(HEADER_BYTES);
  localparam int unsigned FIS_W      = $clog2(FRAMES_PER_POINT + 1);
  localparam int unsigned FLEN_W     = 13;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned POS_W      = 32;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] SYNC_MASK  = 8'hF6;
  localparam logic [7:0] SYNC_VALUE = 8'hF0;

  localparam int unsigned MAX_RESULTS     = 2;
  localparam int unsigned FIFO_DEPTH      = 8;
  localparam int unsigned FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W      = FIFO_PTR_W + 1;
  localparam int unsigned FIFO_SUM_W      = FIFO_CNT_W + 1;
  localparam int unsigned FIFO_ACCEPT_MAX = FIFO_DEPTH - 2 * MAX_RESULTS;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITION_BASE = 1'b0,
    CFG_SEEK_ENABLE   = 1'b1
  } afs_cfg_index_e;

  typedef enum logic [1:0] {
    PH_COLLECT = 2'd0,
    PH_SKIP    = 2'd1,
    PH_STOPPED = 2'd2
  } afs_phase_e;

  typedef enum logic [1:0] {
    KIND_FRAME     = 2'd0,
    KIND_SYNC_LOSS = 2'd1,
    KIND_DATA_END  = 2'd2
  } afs_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } afs_in_beat_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [FLEN_W-1:0] frame_len;
    logic              version_id;
    logic [1:0]        profile;
    logic [3:0]        rate_index;
    logic [2:0]        channel_config;
    logic [CNT_W-1:0]  frame_count;
    logic [31:0]       total_bytes;
    logic              seek_point;
    logic [POS_W-1:0]  seek_position;
    logic [CNT_W-1:0]  seconds_count;
  } afs_out_beat_t;

  typedef struct packed {
    logic       version_id;
    logic [1:0] profile;
    logic [3:0] rate_index;
    logic [2:0] channel_config;
  } afs_lat_t;

  typedef struct packed {
    logic [POS_W-1:0] position_base;
    logic             seek_enable;
  } afs_cfg_t;

  typedef struct packed {
    logic          vld0;
    logic          vld1;
    afs_out_beat_t res0;
    afs_out_beat_t res1;
  } afs_push_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc24(input logic [CNT_W-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic afs_out_beat_t make_result(
    input afs_kind_e         kind,
    input logic [FLEN_W-1:0] flen,
    input logic              point,
    input logic [POS_W-1:0]  pos,
    input afs_lat_t          lat,
    input logic [CNT_W-1:0]  frames,
    input logic [31:0]       bytes,
    input logic [CNT_W-1:0]  secs
  );
    afs_out_beat_t r;
    r.result_kind    = kind;
    r.frame_len      = flen;
    r.version_id     = lat.version_id;
    r.profile        = lat.profile;
    r.rate_index     = lat.rate_index;
    r.channel_config = lat.channel_config;
    r.frame_count    = frames;
    r.total_bytes    = bytes;
    r.seek_point     = point;
    r.seek_position  = pos;
    r.seconds_count  = secs;
    return r;
  endfunction

endpackage

@@ src/afs_cfg_regs.sv @@
module afs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [afs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output afs_pkg::afs_cfg_t                   cfg_o
);

  afs_pkg::afs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (afs_pkg::afs_cfg_index_e'(cfg_index_i))
        afs_pkg::CFG_POSITION_BASE: cfg_d.position_base = cfg_data_i[afs_pkg::POS_W-1:0];
        afs_pkg::CFG_SEEK_ENABLE:   cfg_d.seek_enable   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_base <= '0;
      cfg_q.seek_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/afs_scan.sv @@
module afs_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  afs_pkg::afs_in_beat_t beat_i,
  input  afs_pkg::afs_cfg_t     cfg_i,
  output afs_pkg::afs_push_t    push_o
);

  afs_pkg::afs_phase_e                phase_q, phase_d;
  logic [afs_pkg::BIDX_W-1:0]         bidx_q, bidx_d;
  logic [afs_pkg::FLEN_W-1:0]         skip_q, skip_d;
  logic [afs_pkg::CNT_W-1:0]          frames_q, frames_d;
  logic [31:0]                        bytes_q, bytes_d;
  logic [afs_pkg::FIS_W-1:0]          fis_q, fis_d;
  logic [afs_pkg::CNT_W-1:0]          secs_q, secs_d;
  logic [afs_pkg::POS_W-1:0]          off_q, off_d;
  logic [afs_pkg::POS_W-1:0]          fstart_q, fstart_d;
  afs_pkg::afs_lat_t                  lat_q, lat_d;
  logic [7:0]                         hdr_q [afs_pkg::HDR_KEEP];

  afs_pkg::afs_lat_t                  hdr_lat;
  afs_pkg::afs_push_t                 push;
  afs_pkg::afs_out_beat_t             end_res;
  logic [afs_pkg::FLEN_W-1:0]         flen;
  logic [afs_pkg::FIS_W-1:0]          fis_base;
  logic                               sync_ok;
  logic                               point;
  logic                               end_chk;
  logic                               clear;

  assign sync_ok = (hdr_q[0] == afs_pkg::SYNC_BYTE) &&
                   ((hdr_q[1] & afs_pkg::SYNC_MASK) == afs_pkg::SYNC_VALUE);
  assign flen    = {hdr_q[3][1:0], hdr_q[4], hdr_q[5][7:5]};

  assign hdr_lat.version_id     = hdr_q[1][3];
  assign hdr_lat.profile        = hdr_q[2][7:6];
  assign hdr_lat.rate_index     = hdr_q[2][5:2];
  assign hdr_lat.channel_config = {hdr_q[2][0], hdr_q[3][7:6]};

  assign fis_base = (fis_q >= afs_pkg::FIS_W'(afs_pkg::FRAMES_PER_POINT)) ? '0 : fis_q;

  always_comb begin
    phase_d  = phase_q;
    bidx_d   = bidx_q;
    skip_d   = skip_q;
    frames_d = frames_q;
    bytes_d  = bytes_q;
    fis_d    = fis_q;
    secs_d   = secs_q;
    off_d    = off_q;
    fstart_d = fstart_q;
    lat_d    = lat_q;
    push     = '0;
    end_res  = '0;
    point    = 1'b0;
    end_chk  = 1'b0;
    clear    = 1'b0;

    if (valid_i) begin
      unique case (phase_q)
        afs_pkg::PH_STOPPED: begin
          clear = beat_i.last;
        end
        afs_pkg::PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - 1'b1;
          end
          if (skip_d == '0) begin
            phase_d = afs_pkg::PH_COLLECT;
          end
          off_d   = afs_pkg::sat_inc32(off_q);
          end_chk = 1'b1;
        end
        afs_pkg::PH_COLLECT: begin
          if (bidx_q == '0) begin
            fstart_d = off_q;
          end
          if (bidx_q == afs_pkg::BIDX_W'(afs_pkg::HEADER_BYTES - 1)) begin
            bidx_d = '0;
            if (!sync_ok) begin
              push.vld0 = 1'b1;
              push.res0 = afs_pkg::make_result(afs_pkg::KIND_SYNC_LOSS, '0, 1'b0, '0,
                                               lat_q, frames_q, bytes_q, secs_q);
              if (beat_i.last) begin
                clear = 1'b1;
              end else begin
                phase_d = afs_pkg::PH_STOPPED;
                off_d   = afs_pkg::sat_inc32(off_q);
              end
            end else begin
              if (frames_q == '0) begin
                lat_d = hdr_lat;
              end
              frames_d = afs_pkg::sat_inc24(frames_q);
              bytes_d  = afs_pkg::sat_add32(bytes_q, 32'(flen));
              if (fis_base == '0) begin
                point  = cfg_i.seek_enable;
                secs_d = afs_pkg::sat_inc24(secs_q);
              end
              fis_d     = fis_base + 1'b1;
              push.vld0 = 1'b1;
              push.res0 = afs_pkg::make_result(afs_pkg::KIND_FRAME, flen, point,
                                               afs_pkg::sat_add32(cfg_i.position_base,
                                                                  fstart_q),
                                               lat_d, frames_d, bytes_d, secs_d);
              if (flen > afs_pkg::FLEN_W'(afs_pkg::HEADER_BYTES)) begin
                skip_d  = flen - afs_pkg::FLEN_W'(afs_pkg::HEADER_BYTES);
                phase_d = afs_pkg::PH_SKIP;
              end else begin
                skip_d  = '0;
                phase_d = afs_pkg::PH_COLLECT;
              end
              off_d   = afs_pkg::sat_inc32(off_q);
              end_chk = 1'b1;
            end
          end else begin
            bidx_d  = bidx_q + 1'b1;
            off_d   = afs_pkg::sat_inc32(off_q);
            end_chk = 1'b1;
          end
        end
        default: ;
      endcase

      if (end_chk && beat_i.last) begin
        end_res = afs_pkg::make_result(afs_pkg::KIND_DATA_END, '0, 1'b0, '0,
                                       lat_d, frames_d, bytes_d, secs_d);
        if (push.vld0) begin
          push.vld1 = 1'b1;
          push.res1 = end_res;
        end else begin
          push.vld0 = 1'b1;
          push.res0 = end_res;
        end
        clear = 1'b1;
      end
    end

    if (clear) begin
      phase_d  = afs_pkg::PH_COLLECT;
      bidx_d   = '0;
      skip_d   = '0;
      frames_d = '0;
      bytes_d  = '0;
      fis_d    = '0;
      secs_d   = '0;
      off_d    = '0;
      fstart_d = '0;
      lat_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= afs_pkg::PH_COLLECT;
      bidx_q   <= '0;
      skip_q   <= '0;
      frames_q <= '0;
      bytes_q  <= '0;
      fis_q    <= '0;
      secs_q   <= '0;
      off_q    <= '0;
      fstart_q <= '0;
      lat_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      bidx_q   <= bidx_d;
      skip_q   <= skip_d;
      frames_q <= frames_d;
      bytes_q  <= bytes_d;
      fis_q    <= fis_d;
      secs_q   <= secs_d;
      off_q    <= off_d;
      fstart_q <= fstart_d;
      lat_q    <= lat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && phase_q == afs_pkg::PH_COLLECT &&
        bidx_q < afs_pkg::BIDX_W'(afs_pkg::HDR_KEEP)) begin
      hdr_q[bidx_q[afs_pkg::HDR_IDX_W-1:0]] <= beat_i.data_byte;
    end
  end

  assign push_o = push;

endmodule

@@ src/afs_res_fifo.sv @@
module afs_res_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  afs_pkg::afs_push_t               push_i,
  input  logic                             pop_i,
  output logic [afs_pkg::FIFO_CNT_W-1:0]   level_o,
  output afs_pkg::afs_out_beat_t           data_o
);

  afs_pkg::afs_out_beat_t              mem_q [afs_pkg::FIFO_DEPTH];
  logic [afs_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [afs_pkg::FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [afs_pkg::FIFO_CNT_W-1:0]      level_q, level_d;
  logic [afs_pkg::FIFO_PTR_W-1:0]      wr_ptr_nx;
  logic [afs_pkg::FIFO_CNT_W-1:0]      n_push;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign n_push    = afs_pkg::FIFO_CNT_W'(push_i.vld0) + afs_pkg::FIFO_CNT_W'(push_i.vld1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push[afs_pkg::FIFO_PTR_W-1:0];
    rd_ptr_d = rd_ptr_q + afs_pkg::FIFO_PTR_W'(pop_i);
    level_d  = level_q + n_push - afs_pkg::FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  assign level_o = level_q;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

@@ src/adts_frame_scanner_core.sv @@
// ADTS frame scanner: takes one stream byte per clock while in_stall_o is low and
// reports one result per ADTS frame found (length, first-frame format fields, running
// counts, seek point) plus an end result on sync loss or at the byte flagged last
// (none for a last byte after a sync loss). A byte goes from the input register through
// the scan logic into an eight-beat result queue, which offers each result once written.
// The sustained rate is one byte per cycle while not stalled; input stall rises only
// when the result queue, counting what is still in flight, has fewer than four free
// entries, which happens only while the output side holds stall.
module adts_frame_scanner_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  afs_pkg::afs_in_beat_t            in_beat_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output afs_pkg::afs_out_beat_t           out_beat_o,
  input  logic                             cfg_we_i,
  input  logic [afs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [afs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                                in_valid_q;
  afs_pkg::afs_in_beat_t               in_beat_q;
  afs_pkg::afs_cfg_t                   cfg;
  afs_pkg::afs_push_t                  push;
  logic [afs_pkg::FIFO_CNT_W-1:0]      level;
  logic [afs_pkg::FIFO_SUM_W-1:0]      level_sum;
  logic                                in_accept;
  logic                                pop;

  assign level_sum  = afs_pkg::FIFO_SUM_W'(level) +
                      (in_valid_q ? afs_pkg::FIFO_SUM_W'(afs_pkg::MAX_RESULTS) : '0);
  assign in_stall_o = level_sum > afs_pkg::FIFO_SUM_W'(afs_pkg::FIFO_ACCEPT_MAX);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = level != '0;
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_beat_q <= in_beat_i;
    end
  end

  afs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  afs_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .beat_i  (in_beat_q),
    .cfg_i   (cfg),
    .push_o  (push)
  );

  afs_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .level_o (level),
    .data_o  (out_beat_o)
  );

endmodule
